/* sv/sle_pkg.sv */
package sle_pkg;

  // Default line length, terminator slot included.
  localparam int LINE_BYTES_DEF = 32;

  // Character codes the editor reacts to.
  localparam logic [7:0] CHAR_BELL  = 8'h07;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Output channel codes.
  localparam logic CH_ECHO = 1'b0;
  localparam logic CH_LINE = 1'b1;

  // Letters, digits and space are kept in the line.
  function automatic logic is_storable(input logic [7:0] c);
    logic res;
    res = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
          ((c >= 8'h30) && (c <= 8'h39)) || (c == CHAR_SPACE);
    return res;
  endfunction

  // Upper-case letters are folded to lower case; everything else passes.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] res;
    res = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
    return res;
  endfunction

endpackage

/* sv/serial_line_editor.sv */
// Serial line editor.
// Input channel rx_byte/rx_valid/rx_ready takes one received terminal byte per
// item. Output channel channel/data/last/out_valid/out_ready gives the results
// of that item: echo bytes on channel 0, the finished line on channel 1, and
// last marks the final result of an item. Bytes that cause nothing produce no
// result.
// Each result passes through the sequencer state and then the output register; a
// carriage return on a non-empty line first passes through S_FETCH, as it first
// reads the line memory.
// An item that echoes one byte gives one result, a backspace gives three, and a
// carriage return reads the line memory, then sends one stored byte per cycle
// while the receiver does not stall, then the terminator; on an empty line it
// sends only the terminator. Ignored bytes give no result.
// rx_ready is high only while no item is being worked on, but the last result
// of an item may still wait in the output register while the next item is
// taken in.
// Reset empties the line; the memory itself is not cleared, since only
// entries below the fill count are ever read.
// When the receiver stalls, the output register holds its result and the
// block waits, with no result lost or repeated.
module serial_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       rx_valid,
  output logic       rx_ready,
  output logic       channel,
  output logic [7:0] data,
  output logic       last,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam int CAPACITY = LINE_BYTES - 1;
  localparam int CW = $clog2(LINE_BYTES);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ECHO  = 6'b000010,
    S_BS    = 6'b000100,
    S_FETCH = 6'b001000,
    S_LINE  = 6'b010000,
    S_TERM  = 6'b100000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   fill_count, fill_count_next;
  logic [CW-1:0]   rd_idx, rd_idx_next;
  logic [CW-1:0]   rd_idx_inc;
  logic [7:0]      echo_byte, echo_byte_next;
  logic [1:0]      bs_step, bs_step_next;

  logic            accept, out_free, rd_last, line_full;
  logic            push, push_channel, push_last;
  logic [7:0]      push_data;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  assign rx_ready   = (state == S_IDLE);
  assign accept     = rx_valid && rx_ready;
  assign out_free   = !out_valid || out_ready;
  assign line_full  = (fill_count == CAP_C);
  assign rd_idx_inc = rd_idx + 1'b1;
  assign rd_last    = (rd_idx_inc == fill_count);

  // Storable bytes are written at the fill position as they are accepted, unless the line is full.
  assign ram_we    = accept && is_storable(rx_byte) && !line_full;
  assign ram_waddr = fill_count[AW-1:0];
  assign ram_wdata = to_lower(rx_byte);

  // Read ahead by one entry whenever a line byte other than the last leaves, else hold the address.
  assign ram_raddr = ((state == S_LINE) && out_free && !rd_last) ?
                     rd_idx_inc[AW-1:0] : rd_idx[AW-1:0];

  sle_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer: decode an accepted byte, then issue its results one by one.
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    rd_idx_next     = rd_idx;
    echo_byte_next  = echo_byte;
    bs_step_next    = bs_step;
    push            = 1'b0;
    push_channel    = CH_ECHO;
    push_data       = CHAR_NUL;
    push_last       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (rx_byte == CHAR_CR) begin
            rd_idx_next = '0;
            state_next  = (fill_count == '0) ? S_TERM : S_FETCH;
          end else if ((rx_byte == CHAR_BS) || (rx_byte == CHAR_DEL)) begin
            if (fill_count != '0) begin
              fill_count_next = fill_count - 1'b1;
              bs_step_next    = 2'd0;
              state_next      = S_BS;
            end
          end else if (is_storable(rx_byte)) begin
            if (line_full) begin
              echo_byte_next = CHAR_BELL;
            end else begin
              echo_byte_next  = rx_byte;
              fill_count_next = fill_count + 1'b1;
            end
            state_next = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (out_free) begin
          push       = 1'b1;
          push_data  = echo_byte;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BS: begin
        if (out_free) begin
          push         = 1'b1;
          push_data    = (bs_step == 2'd1) ? CHAR_SPACE : CHAR_BS;
          push_last    = (bs_step == 2'd2);
          bs_step_next = bs_step + 2'd1;
          if (bs_step == 2'd2) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        // First entry is being read from the memory.
        state_next = S_LINE;
      end
      S_LINE: begin
        if (out_free) begin
          push         = 1'b1;
          push_channel = CH_LINE;
          push_data    = ram_rdata;
          rd_idx_next  = rd_idx_inc;
          if (rd_last) begin
            state_next = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          push            = 1'b1;
          push_channel    = CH_LINE;
          push_data       = CHAR_NUL;
          push_last       = 1'b1;
          fill_count_next = '0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rd_idx     <= '0;
      bs_step    <= 2'd0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      rd_idx     <= rd_idx_next;
      bs_step    <= bs_step_next;
    end
  end

  always_ff @(posedge clk) begin
    echo_byte <= echo_byte_next;
  end

  // Output register: loaded on a push, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      channel <= push_channel;
      data    <= push_data;
      last    <= push_last;
    end
  end

endmodule

/* sv/sle_ram.sv */
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sle_checker.sv */
module sle_checker
  import sle_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       channel,
  input logic [7:0] data,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(data) &&
                                $stable(last))
    else $error("result changed while stalled");

  // The line ends with a zero terminator.
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel == CH_LINE) && last |-> data == CHAR_NUL)
    else $error("line terminator is not zero");

  // Stored line characters are never zero.
  a_line_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel == CH_LINE) && !last |-> data != CHAR_NUL)
    else $error("zero byte inside a line");

  // Only the backspace sequence has echo results that are not last.
  a_bs_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel == CH_ECHO) && !last |->
      (data == CHAR_BS) || (data == CHAR_SPACE))
    else $error("unexpected echo inside an item");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import sle_pkg::*;

  // Characters the line can hold; the last slot of the line is reserved.
  localparam int LINE_CAP    = LINE_BYTES_DEF - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 20;

  // One result of the editor as the checker expects to see it.
  typedef struct packed {
    logic       chan;
    logic [7:0] value;
    logic       tail;
  } out_beat_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic [7:0] rx_byte   = 8'h00;
  logic       rx_valid  = 1'b0;
  logic       rx_ready;
  logic       channel;
  logic [7:0] data;
  logic       last;
  logic       out_valid;
  logic       out_ready = 1'b1;

  // Predicted line contents and the results still owed by the editor.
  logic [7:0] line_text [0:LINE_CAP-1];
  int         line_fill;
  out_beat_t  pending_beats [$];
  out_beat_t  oldest_beat;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int bytes_sent     = 0;
  int busy_items     = 0;
  int results_seen   = 0;
  int lines_done     = 0;
  int bells_rung     = 0;

  serial_line_editor i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .channel   (channel),
    .data      (data),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  always #2 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_beats.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("Mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Each accepted result is compared with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result channel=%0d data=%02h last=%0d",
                                  channel, data, last));
      end else begin
        oldest_beat = pending_beats.pop_front();
        if (channel !== oldest_beat.chan)
          report_mismatch($sformatf("channel %0d, expected %0d", channel, oldest_beat.chan));
        if (data !== oldest_beat.value)
          report_mismatch($sformatf("data %02h, expected %02h", data, oldest_beat.value));
        if (last !== oldest_beat.tail)
          report_mismatch($sformatf("last %0d, expected %0d", last, oldest_beat.tail));
      end
    end
  end

  function automatic void queue_beat(input logic chan, input logic [7:0] value,
                                     input logic tail);
    out_beat_t beat;
    beat.chan  = chan;
    beat.value = value;
    beat.tail  = tail;
    pending_beats.push_back(beat);
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  // Letters, digits and space belong in the line.
  function automatic logic is_line_char(input logic [7:0] b);
    return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == CHAR_SPACE);
  endfunction

  // Works out the results of one accepted byte and updates the predicted line.
  task automatic edit_line(input logic [7:0] b, output int n_out);
    int before_size;
    int i;
    before_size = pending_beats.size();
    if (b == CHAR_CR) begin
      for (i = 0; i < line_fill; i++)
        queue_beat(CH_LINE, line_text[i], 1'b0);
      queue_beat(CH_LINE, CHAR_NUL, 1'b1);
      line_fill = 0;
      lines_done++;
    end else if ((b == CHAR_BS) || (b == CHAR_DEL)) begin
      if (line_fill > 0) begin
        line_fill--;
        queue_beat(CH_ECHO, CHAR_BS, 1'b0);
        queue_beat(CH_ECHO, CHAR_SPACE, 1'b0);
        queue_beat(CH_ECHO, CHAR_BS, 1'b1);
      end
    end else if (is_line_char(b)) begin
      if (line_fill < LINE_CAP) begin
        line_text[line_fill] = is_upper(b) ? (b | 8'h20) : b;
        line_fill++;
        queue_beat(CH_ECHO, b, 1'b1);
      end else begin
        queue_beat(CH_ECHO, CHAR_BELL, 1'b1);
        bells_rung++;
      end
    end
    n_out = pending_beats.size() - before_size;
  endtask

  // Offers one byte, with random idle cycles first, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b);
    int n_out;
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    edit_line(b, n_out);
    bytes_sent++;
    if (n_out > 0) busy_items++;
  endtask

  // Holds the sender back until every expected result has come.
  task automatic wait_drained();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_line_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'h41 + 8'($urandom_range(0, 25));
      3, 4, 5: b = 8'h61 + 8'($urandom_range(0, 25));
      6, 7, 8: b = 8'h30 + 8'($urandom_range(0, 9));
      default: b = CHAR_SPACE;
    endcase
    return b;
  endfunction

  // Field extremes, class boundaries and the empty-line cases.
  task automatic test_directed_bytes();
    logic [7:0] seq [24] = '{
      CHAR_BS, CHAR_DEL, CHAR_CR, 8'h00, 8'hFF, 8'h80, 8'h40, 8'h5B,
      8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h1F, 8'h21, 8'h41, 8'h5A,
      8'h61, 8'h7A, 8'h30, 8'h39, CHAR_SPACE, CHAR_BS, CHAR_DEL, CHAR_CR
    };
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (i = 0; i < 24; i++) send_byte(seq[i]);
    wait_drained();
  endtask

  // Fills the line to capacity, rings the bell, then reads out a full line.
  task automatic test_full_line();
    int i;
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    for (i = 0; i < LINE_CAP + 2; i++) send_byte(random_line_char());
    send_byte(CHAR_DEL);
    send_byte(random_line_char());
    send_byte(random_line_char());
    send_byte(CHAR_CR);
    wait_drained();
  endtask

  // Mostly typed lines with the odd correction, mixed with stray bytes.
  task automatic run_traffic(input int n_items, input int tx_idle, input int rx_stall);
    int target;
    int len;
    int k;
    int burst;
    send_idle_pct  = tx_idle;
    recv_stall_pct = rx_stall;
    target = busy_items + n_items;
    while (busy_items < target) begin
      if ($urandom_range(0, 4) != 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0)
            send_byte($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
          else
            send_byte(random_line_char());
        end
        send_byte(CHAR_CR);
      end else begin
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst; k++) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_traffic(45, 0, 0);
    run_traffic(45, 79, 0);
    run_traffic(45, 0, 79);
    run_traffic(45, 26, 26);
  endtask

  initial begin
    line_fill = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_bytes();
    test_full_line();
    test_random_traffic();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d bytes (%0d with results), checked %0d results, %0d lines, %0d bells.",
             bytes_sent, busy_items, results_seen, lines_done, bells_rung);
    $display("Phases ran with no idling, sender idling, receiver stalling and both.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* serial_line_editor.f */
sv/sle_pkg.sv
sv/sle_ram.sv
sv/serial_line_editor.sv
sv/sle_checker.sv
bench/testbench.sv
